/* rtl/core/lsh_pkg.sv */
// Shared constants, types and state codes of the LSH collision-counting candidate generator.
`default_nettype none
package lsh_pkg;

    // Fixed field widths
    localparam int ID_W      = 10;
    localparam int ID_SPACE  = 1024;
    localparam int CNT_W     = 5;
    localparam int KEY_W     = 32;
    localparam int RANGE_W   = 31;
    localparam int WIDTH_W   = 32;
    localparam int RATIO_W   = 16;
    localparam int TOPK_W    = 6;
    localparam int CAND_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CNT_W-1:0]   CNT_SAT   = 5'd31;
    localparam logic [RANGE_W-1:0] UNLIMITED = 31'h7FFF_FFFF;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 16'd4096;
    localparam int                 TOPK_MAX  = 32;

    // Parameter defaults
    localparam int DEF_MAX_TABLES     = 16;
    localparam int DEF_MAX_POINTS     = 1024;
    localparam int DEF_CANDIDATE_BASE = 32;
    localparam int DEF_SCAN_BURST     = 64;

    // Register reset values
    localparam logic [4:0]  RST_TABLES    = 5'd16;
    localparam logic [10:0] RST_POINTS    = 11'd1024;
    localparam logic [4:0]  RST_THRESHOLD = 5'd8;
    localparam logic [30:0] RST_HALF_W    = 31'd89128;
    localparam logic [15:0] RST_RATIO     = 16'd8192;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLES    = 3'd0,
        CFG_POINTS    = 3'd1,
        CFG_THRESHOLD = 3'd2,
        CFG_HALF_W    = 3'd3,
        CFG_RATIO     = 3'd4
    } cfg_idx_t;

    // Input kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Search sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BS_NEXT,
        ST_BS_RD,
        ST_BS_CMP,
        ST_ROUND,
        ST_TABLE,
        ST_SIDE,
        ST_CHK,
        ST_CNT,
        ST_TEND,
        ST_REND,
        ST_MUL,
        ST_WUPD,
        ST_FIN
    } st_t;

    // Write request into the collision count memory
    typedef struct packed {
        logic             en;
        logic [ID_W-1:0]  addr;
        logic [CNT_W-1:0] count;
        logic             mark;
    } cnt_wr_t;

endpackage
`default_nettype wire

/* rtl/core/lsh_in_if.sv */
// Input channel: load entries and query keys.
`default_nettype none
interface lsh_in_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [3:0]        table_index;
    logic [9:0]        entry_index;
    logic signed [31:0] key;
    logic [9:0]        point_id;
    logic [5:0]        top_k;
    logic [30:0]       search_range;
    logic              query_done;

    modport source (output valid, kind, table_index, entry_index, key, point_id, top_k,
                    search_range, query_done, input ready);
    modport sink   (input valid, kind, table_index, entry_index, key, point_id, top_k,
                    search_range, query_done, output ready);
endinterface
`default_nettype wire

/* rtl/core/lsh_out_if.sv */
// Output channel: candidate ids.
`default_nettype none
interface lsh_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] candidate_id;
    logic       candidate_valid;
    logic       last;

    modport source (output valid, candidate_id, candidate_valid, last, input ready);
    modport sink   (input valid, candidate_id, candidate_valid, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/lsh_store.sv */
// Sorted key and point id memory of all hash tables, one write and one read port.
`default_nettype none
module lsh_store #(
    parameter int TW = 4,
    parameter int PW = 10
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [TW+PW-1:0]          wr_addr,
    input  wire logic [lsh_pkg::KEY_W-1:0] wr_key,
    input  wire logic [lsh_pkg::ID_W-1:0]  wr_id,
    input  wire logic                      rd_en,
    input  wire logic [TW+PW-1:0]          rd_addr,
    output logic      [lsh_pkg::KEY_W-1:0] rd_key,
    output logic      [lsh_pkg::ID_W-1:0]  rd_id
);
    import lsh_pkg::*;

    localparam int DEPTH = 2 ** (TW + PW);

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [ID_W-1:0]  id_mem  [DEPTH];

    // Write a loaded entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            id_mem[wr_addr]  <= wr_id;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key <= key_mem[rd_addr];
            rd_id  <= id_mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/lsh_cnt.sv */
// Per-point collision count and emitted mark memory.
`default_nettype none
module lsh_cnt (
    input  wire logic                      clk,
    input  wire lsh_pkg::cnt_wr_t          wr,
    input  wire logic                      rd_en,
    input  wire logic [lsh_pkg::ID_W-1:0]  rd_addr,
    output logic      [lsh_pkg::CNT_W-1:0] rd_count,
    output logic                           rd_mark
);
    import lsh_pkg::*;

    logic [CNT_W:0] mem [ID_SPACE];

    // Write back count and mark
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.mark, wr.count};
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            {rd_mark, rd_count} <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/lsh_collision_count_candidates.sv */
// Top level: search sequencer of the LSH collision-counting candidate generator.
//
//  port     | dir | beat
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | load entry or query key; query_done starts the search
//  out_ch   | out | one candidate id, or an empty end beat; last closes query
//  cfg_*    | in  | register write, one per cycle
//
//  Load and query-key beats are taken one per cycle while idle. A beat with
//  query_done holds the input for the search: a clear of all 1024 entries of
//  the count memory, binary-search probes, scanned entries (store read,
//  count read-modify-write) and width updates (round-end check, multiply,
//  saturate).
//  Reset leaves the block idle; a stalled output holds the sequencer only when
//  a beat must leave while the output register is still full.
`default_nettype none
module lsh_collision_count_candidates #(
    parameter int MAX_TABLES     = lsh_pkg::DEF_MAX_TABLES,
    parameter int MAX_POINTS     = lsh_pkg::DEF_MAX_POINTS,
    parameter int CANDIDATE_BASE = lsh_pkg::DEF_CANDIDATE_BASE,
    parameter int SCAN_BURST     = lsh_pkg::DEF_SCAN_BURST
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lsh_in_if.sink                              in_ch,
    lsh_out_if.source                           out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsh_pkg::*;

    localparam int TW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int MW  = $clog2(MAX_TABLES + 1);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int KW  = $clog2(SCAN_BURST + 1);
    localparam int AW  = TW + PW;

    // Configuration registers
    logic [4:0]  tables_reg;
    logic [10:0] points_reg;
    logic [4:0]  thr_reg;
    logic [30:0] half_w_reg;
    logic [15:0] ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tables_reg <= RST_TABLES;
            points_reg <= RST_POINTS;
            thr_reg    <= RST_THRESHOLD;
            half_w_reg <= RST_HALF_W;
            ratio_reg  <= RST_RATIO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TABLES:    tables_reg <= cfg_data[4:0];
                CFG_POINTS:    points_reg <= cfg_data[10:0];
                CFG_THRESHOLD: thr_reg    <= cfg_data[4:0];
                CFG_HALF_W:    half_w_reg <= cfg_data[30:0];
                CFG_RATIO:     ratio_reg  <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Sequencer state
    st_t               state_reg, state_next;
    logic [MW-1:0]     m_reg, m_next, t_reg, t_next, cb_reg, cb_next, cr_reg, cr_next;
    logic [PCW-1:0]    n_reg, n_next, lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CAND_W-1:0] cap_reg, cap_next, cnt_reg, cnt_next;
    logic [RANGE_W-1:0] range_reg, range_next;
    logic [WIDTH_W-1:0] w_reg, w_next;
    logic [WIDTH_W+RATIO_W-1:0] prod_reg, prod_next;
    logic [ID_W-1:0]   clr_reg, clr_next, pend_id_reg, pend_id_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              side_reg, side_next;
    logic              lw_reg, lw_next, lr_reg, lr_next, rw_reg, rw_next, rr_reg, rr_next;
    logic [KEY_W-1:0]  qkey_reg [MAX_TABLES];
    logic [PCW-1:0]    lpos_reg [MAX_TABLES];
    logic [PCW-1:0]    lpos_next [MAX_TABLES];
    logic [PCW-1:0]    rpos_reg [MAX_TABLES];
    logic [PCW-1:0]    rpos_next [MAX_TABLES];
    logic [MAX_TABLES-1:0] bopen_reg, bopen_next, ropen_reg, ropen_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_cv_reg, out_cv_next, out_last_reg, out_last_next;

    // Memory ports
    logic              st_wr_en, st_rd_en, cn_rd_en;
    logic [AW-1:0]     st_wr_addr, st_rd_addr;
    logic [KEY_W-1:0]  st_rd_key;
    logic [ID_W-1:0]   st_rd_id, cn_rd_addr;
    logic [CNT_W-1:0]  cn_rd_count;
    logic              cn_rd_mark;
    cnt_wr_t           cn_wr;

    logic              in_acc, out_free;
    logic [TW-1:0]     ti;
    logic [31:0]       tab_ext, ent_ext;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign ti          = t_reg[TW-1:0];
    assign tab_ext     = 32'(in_ch.table_index);
    assign ent_ext     = 32'(in_ch.entry_index);

    // Load path into the store
    assign st_wr_en   = in_acc && (in_ch.kind == KIND_LOAD) && (tab_ext < MAX_TABLES)
                        && (ent_ext < MAX_POINTS);
    assign st_wr_addr = {tab_ext[TW-1:0], ent_ext[PW-1:0]};

    lsh_store #(.TW(TW), .PW(PW)) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_key  (in_ch.key),
        .wr_id   (in_ch.point_id),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_key  (st_rd_key),
        .rd_id   (st_rd_id)
    );

    lsh_cnt u_cnt (
        .clk      (clk),
        .wr       (cn_wr),
        .rd_en    (cn_rd_en),
        .rd_addr  (cn_rd_addr),
        .rd_count (cn_rd_count),
        .rd_mark  (cn_rd_mark)
    );

    // Next state and datapath
    always_comb
    begin
        logic [31:0]       m_full, n_full, tk;
        logic [KEY_W:0]    diff, gap;
        logic              far_w, far_r, adv, emit, stall, bo;
        logic [CNT_W-1:0]  nc;
        logic [PCW-1:0]    pos;
        logic [35:0]       p;
        logic [WIDTH_W:0]  wp1;
        logic [WIDTH_W-1:0] wn;

        state_next = state_reg;
        m_next = m_reg; t_next = t_reg; cb_next = cb_reg; cr_next = cr_reg;
        n_next = n_reg; lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        cap_next = cap_reg; cnt_next = cnt_reg; range_next = range_reg;
        w_next = w_reg; prod_next = prod_reg; clr_next = clr_reg;
        pend_id_next = pend_id_reg; pend_valid_next = pend_valid_reg;
        k_next = k_reg; side_next = side_reg;
        lw_next = lw_reg; lr_next = lr_reg; rw_next = rw_reg; rr_next = rr_reg;
        lpos_next = lpos_reg; rpos_next = rpos_reg;
        bopen_next = bopen_reg; ropen_next = ropen_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_id_next = out_id_reg; out_cv_next = out_cv_reg; out_last_next = out_last_reg;
        st_rd_en = 1'b0; st_rd_addr = '0;
        cn_rd_en = 1'b0; cn_rd_addr = st_rd_id;
        cn_wr = '0;
        m_full = 32'(tables_reg); n_full = 32'(points_reg); tk = 32'(in_ch.top_k);
        diff = {st_rd_key[KEY_W-1], st_rd_key} - {st_rd_key[KEY_W-1], st_rd_key};
        gap = '0; far_w = 1'b0; far_r = 1'b0; adv = 1'b0; emit = 1'b0; stall = 1'b0;
        bo = 1'b0; nc = '0; pos = '0; p = '0; wp1 = '0; wn = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take loads and query keys; start on the final key
                if (in_acc && (in_ch.kind == KIND_QUERY))
                begin
                    if (tab_ext < MAX_TABLES)
                    begin
                        // key stored in payload block
                    end
                    if (in_ch.query_done)
                    begin
                        if (m_full < 1) m_full = 1;
                        if (m_full > MAX_TABLES) m_full = MAX_TABLES;
                        if (n_full < 1) n_full = 1;
                        if (n_full > MAX_POINTS) n_full = MAX_POINTS;
                        if (tk < 1) tk = 1;
                        if (tk > TOPK_MAX) tk = TOPK_MAX;
                        m_next     = m_full[MW-1:0];
                        n_next     = n_full[PCW-1:0];
                        cap_next   = CAND_W'(CANDIDATE_BASE + tk - 1);
                        range_next = in_ch.search_range;
                        cnt_next   = '0;
                        cr_next    = '0;
                        w_next     = {1'b0, half_w_reg};
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Sweep the count memory to zero
                cn_wr.en   = 1'b1;
                cn_wr.addr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ID_W'(ID_SPACE - 1))
                begin
                    t_next     = '0;
                    state_next = ST_BS_NEXT;
                end
            end
            ST_BS_NEXT:
            begin
                if (t_reg == m_reg)
                begin
                    t_next     = '0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = n_reg;
                    state_next = ST_BS_RD;
                end
            end
            ST_BS_RD:
            begin
                // Probe the middle entry, or settle this table's start
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                    st_rd_en   = 1'b1;
                    st_rd_addr = {ti, mid_next[PW-1:0]};
                    state_next = ST_BS_CMP;
                end
                else
                begin
                    lpos_next[ti]  = lo_reg;
                    rpos_next[ti]  = lo_reg;
                    ropen_next[ti] = 1'b1;
                    t_next         = t_reg + 1'b1;
                    state_next     = ST_BS_NEXT;
                end
            end
            ST_BS_CMP:
            begin
                if ($signed(st_rd_key) < $signed(qkey_reg[ti]))
                    lo_next = mid_reg + 1'b1;
                else
                    hi_next = mid_reg;
                state_next = ST_BS_RD;
            end
            ST_ROUND:
            begin
                bopen_next = '1;
                cb_next    = '0;
                t_next     = '0;
                state_next = ST_TABLE;
            end
            ST_TABLE:
            begin
                if (!bopen_reg[ti])
                    adv = 1'b1;
                else
                begin
                    k_next = '0; side_next = 1'b0;
                    lw_next = 1'b0; lr_next = 1'b0; rw_next = 1'b0; rr_next = 1'b0;
                    state_next = ST_SIDE;
                end
            end
            ST_SIDE:
            begin
                // Issue the next entry of the burst or close this side
                if (k_reg == KW'(SCAN_BURST))
                begin
                    if (!side_reg)
                    begin
                        side_next = 1'b1; k_next = '0;
                    end
                    else
                        state_next = ST_TEND;
                end
                else if (!side_reg)
                begin
                    if (lpos_reg[ti] == '0)
                    begin
                        lw_next = 1'b1; lr_next = 1'b1;
                        side_next = 1'b1; k_next = '0;
                    end
                    else
                    begin
                        pos        = lpos_reg[ti] - 1'b1;
                        st_rd_en   = 1'b1;
                        st_rd_addr = {ti, pos[PW-1:0]};
                        state_next = ST_CHK;
                    end
                end
                else
                begin
                    if (rpos_reg[ti] >= n_reg)
                    begin
                        rw_next = 1'b1; rr_next = 1'b1;
                        state_next = ST_TEND;
                    end
                    else
                    begin
                        pos        = rpos_reg[ti];
                        st_rd_en   = 1'b1;
                        st_rd_addr = {ti, pos[PW-1:0]};
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                // Distance test against width and range
                diff  = {qkey_reg[ti][KEY_W-1], qkey_reg[ti]}
                        - {st_rd_key[KEY_W-1], st_rd_key};
                gap   = diff[KEY_W] ? (~diff + 1'b1) : diff;
                far_w = gap > {1'b0, w_reg};
                far_r = (range_reg != UNLIMITED) && (gap > (KEY_W+1)'(range_reg));
                if (far_w || far_r)
                begin
                    if (!side_reg)
                    begin
                        lw_next = far_w; lr_next = far_r;
                        side_next = 1'b1; k_next = '0;
                        state_next = ST_SIDE;
                    end
                    else
                    begin
                        rw_next = far_w; rr_next = far_r;
                        state_next = ST_TEND;
                    end
                end
                else
                begin
                    cn_rd_en   = 1'b1;
                    state_next = ST_CNT;
                end
            end
            ST_CNT:
            begin
                // Count the collision and emit on reaching the threshold
                nc    = (cn_rd_count < CNT_SAT) ? cn_rd_count + 1'b1 : cn_rd_count;
                emit  = (nc >= thr_reg) && !cn_rd_mark;
                stall = emit && pend_valid_reg && !out_free;
                if (!stall)
                begin
                    cn_wr.en    = 1'b1;
                    cn_wr.addr  = st_rd_id;
                    cn_wr.count = nc;
                    cn_wr.mark  = cn_rd_mark || emit;
                    if (emit && pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = pend_id_reg;
                        out_cv_next    = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    if (emit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = st_rd_id;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    if (emit && (cnt_next >= cap_reg))
                        state_next = ST_FIN;
                    else
                    begin
                        if (!side_reg)
                            lpos_next[ti] = lpos_reg[ti] - 1'b1;
                        else
                            rpos_next[ti] = rpos_reg[ti] + 1'b1;
                        k_next     = k_reg + 1'b1;
                        state_next = ST_SIDE;
                    end
                end
            end
            ST_TEND:
            begin
                // Close the bucket and the range as the two sides say
                bo = bopen_reg[ti];
                if (lw_reg && rw_reg)
                begin
                    bo = 1'b0; cb_next = cb_next + 1'b1;
                end
                if (lr_reg && rr_reg)
                begin
                    if (bo)
                    begin
                        bo = 1'b0; cb_next = cb_next + 1'b1;
                    end
                    if (ropen_reg[ti])
                    begin
                        ropen_next[ti] = 1'b0; cr_next = cr_reg + 1'b1;
                    end
                end
                bopen_next[ti] = bo;
                adv = 1'b1;
            end
            ST_REND:
            begin
                if ((cr_reg >= m_reg) || (ratio_reg <= RATIO_ONE))
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = w_reg * ratio_reg;
                state_next = ST_WUPD;
            end
            ST_WUPD:
            begin
                // Grow the width by at least one, saturate
                p   = prod_reg[WIDTH_W+RATIO_W-1:12];
                wp1 = {1'b0, w_reg} + 1'b1;
                if (p < 36'(wp1)) p = 36'(wp1);
                wn  = (p > 36'hFFFF_FFFF) ? '1 : p[WIDTH_W-1:0];
                if (wn == w_reg)
                    state_next = ST_FIN;
                else
                begin
                    w_next     = wn;
                    state_next = ST_ROUND;
                end
            end
            ST_FIN:
            begin
                // Send the held candidate as last, or the empty end beat
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    out_cv_next     = pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Advance to the next table or end the round
        if (adv)
        begin
            if (32'(t_reg) + 1 < 32'(m_reg))
            begin
                t_next     = t_reg + 1'b1;
                state_next = ST_TABLE;
            end
            else if ((cb_next < m_reg) && (cr_next < m_reg))
            begin
                t_next     = '0;
                state_next = ST_TABLE;
            end
            else
                state_next = ST_REND;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_reg <= '0; t_reg <= '0; cb_reg <= '0; cr_reg <= '0;
            n_reg <= '0; lo_reg <= '0; hi_reg <= '0; mid_reg <= '0;
            cap_reg <= '0; cnt_reg <= '0; w_reg <= '0; clr_reg <= '0;
            pend_valid_reg <= 1'b0;
            k_reg <= '0; side_reg <= 1'b0;
            lw_reg <= 1'b0; lr_reg <= 1'b0; rw_reg <= 1'b0; rr_reg <= 1'b0;
            for (int i = 0; i < MAX_TABLES; i++)
            begin
                lpos_reg[i] <= '0;
                rpos_reg[i] <= '0;
            end
            bopen_reg     <= '1;
            ropen_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            m_reg <= m_next; t_reg <= t_next; cb_reg <= cb_next; cr_reg <= cr_next;
            n_reg <= n_next; lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next;
            cap_reg <= cap_next; cnt_reg <= cnt_next; w_reg <= w_next; clr_reg <= clr_next;
            pend_valid_reg <= pend_valid_next;
            k_reg <= k_next; side_reg <= side_next;
            lw_reg <= lw_next; lr_reg <= lr_next; rw_reg <= rw_next; rr_reg <= rr_next;
            lpos_reg      <= lpos_next;
            rpos_reg      <= rpos_next;
            bopen_reg     <= bopen_next;
            ropen_reg     <= ropen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        range_reg    <= range_next;
        prod_reg     <= prod_next;
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_cv_reg   <= out_cv_next;
        out_last_reg <= out_last_next;
        if (in_acc && (in_ch.kind == KIND_QUERY) && (tab_ext < MAX_TABLES))
            qkey_reg[tab_ext[TW-1:0]] <= in_ch.key;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.candidate_id    = out_id_reg;
    assign out_ch.candidate_valid = out_cv_reg;
    assign out_ch.last            = out_last_reg;

    // Checks
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (cnt_reg <= cap_reg))
        else $error("candidate count above cap");
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input taken during search");
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("candidate held while idle");
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (out_ch.valid && out_ch.last))
        else $error("search end without last beat");

endmodule
`default_nettype wire
